### design/ffkvs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffkvs_pkg
// Shared codes and fixed record-format constants of the key/value store.
// ----------------------------------------------------------------------------
package ffkvs_pkg;

    localparam logic [7:0] MARK_FREE = 8'h41;
    localparam logic [7:0] MARK_USED = 8'h46;

    localparam int HEAD    = 5;
    localparam int TAIL    = 2;
    localparam int BLK_MIN = HEAD + TAIL;

    typedef enum logic [1:0] {
        ACT_FORMAT = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_LOOKUP = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_NO_SPACE  = 2'd2,
        ST_BAD_LEN   = 2'd3
    } t_status;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_HEAD  = 8'b0000_0100,
        S_CHECK = 8'b0000_1000,
        S_KEY   = 8'b0001_0000,
        S_FILL  = 8'b0010_0000,
        S_DATA  = 8'b0100_0000,
        S_RESP  = 8'b1000_0000
    } t_state;

endpackage

### design/ffkvs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffkvs_ram
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ffkvs_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/first_fit_key_value_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_key_value_store
// Byte store of boundary-tagged records, first-fit insert and key lookup.
// ----------------------------------------------------------------------------
// Input stream: tuser selects format, insert byte or lookup key byte; tdata
// carries key length, data length and the byte; tlast closes an operation.
// A byte without tlast is staged. On tlast an insert or lookup walks the
// block chain in the store RAM (single read port). An insert then rewrites
// the chosen block, one byte per cycle. A lookup compares the key byte by
// byte against each candidate and returns the data one byte at a time,
// reading the next byte only after the last one is taken into the output
// register. Format clears the store, then returns one status transfer.
// Output stream: tuser is the status, tdata holds the data byte and found
// length, tlast marks the final transfer of an operation.
// Reset runs the same clearing pass with tready low.
// A stalled receiver holds the output register; data and status output wait
// for it, and a new input is taken as soon as the engine is back in idle.
// ----------------------------------------------------------------------------
module first_fit_key_value_store #(
    parameter int STORE_SIZE = 4096,
    parameter int DATA_MAX   = 64,
    parameter int KEY_MAX    = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // key_len[7:0], data_len[14:8], byte_value[22:15]
    input  logic        s_axis_tlast,
    input  logic [1:0]  s_axis_tuser,  // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // data_byte[7:0], found_len[14:8]
    output logic        m_axis_tlast,
    output logic [1:0]  m_axis_tuser   // status[1:0]
);

    localparam int AW        = $clog2(STORE_SIZE);
    localparam int OW        = $clog2(STORE_SIZE + 8);
    localparam int STG_DEPTH = KEY_MAX + DATA_MAX + 1;
    localparam int SW        = $clog2(STG_DEPTH);
    localparam int CW        = $clog2(STG_DEPTH + 1);
    localparam logic [15:0] STORE_SZ = 16'(STORE_SIZE);

    ffkvs_pkg::t_state  r_state;
    ffkvs_pkg::t_status r_status;
    ffkvs_pkg::t_status r_mstat;
    ffkvs_pkg::t_action w_act;

    logic [OW-1:0] r_cnt;
    logic [OW-1:0] r_off;
    logic [7:0]    r_hdr [5];
    logic [15:0]   r_bsz;
    logic          r_op;
    logic [7:0]    r_klen;
    logic [6:0]    r_dlen;
    logic [15:0]   r_rec;
    logic [15:0]   r_size;
    logic [15:0]   r_rem;
    logic          r_split;
    logic [6:0]    r_dl;
    logic          r_fmt;
    logic          r_wv;
    logic [15:0]   r_wp;
    logic [CW-1:0] r_scnt;
    logic          r_ph;
    logic          r_mvalid;
    logic [7:0]    r_mdata;
    logic [6:0]    r_mlen;
    logic          r_mlast;

    logic [7:0]    w_klen;
    logic [6:0]    w_dlen;
    logic [7:0]    w_byte;
    logic          w_acc;
    logic          w_slot;
    logic          w_mload;
    logic [15:0]   w_sz;
    logic          w_broken;
    logic          w_head_oob;
    logic [CW-1:0] w_scnt_n;
    logic          w_bad_ins;
    logic          w_bad_lkp;
    logic          w_split;
    logic [15:0]   w_room;
    logic [15:0]   w_dl16;
    logic [6:0]    w_dl;
    logic [15:0]   w_clr_p;

    logic          st_we;
    logic [AW-1:0] st_waddr;
    logic [7:0]    st_wdata;
    logic          st_re;
    logic [AW-1:0] st_raddr;
    logic [7:0]    st_rdata;
    logic          sg_we;
    logic          sg_re;
    logic [SW-1:0] sg_raddr;
    logic [7:0]    sg_rdata;

    assign w_act  = ffkvs_pkg::t_action'(s_axis_tuser);
    assign w_klen = s_axis_tdata[7:0];
    assign w_dlen = s_axis_tdata[14:8];
    assign w_byte = s_axis_tdata[22:15];

    assign s_axis_tready = (r_state == ffkvs_pkg::S_IDLE);
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_slot        = !r_mvalid || m_axis_tready;
    assign w_mload       = w_slot && ((r_state == ffkvs_pkg::S_DATA && r_ph) ||
                                      r_state == ffkvs_pkg::S_RESP);

    assign w_sz       = {r_hdr[2], r_hdr[1]};
    assign w_broken   = (w_sz < 16'(ffkvs_pkg::BLK_MIN)) ||
                        ({1'b0, w_sz} > 17'(STORE_SIZE) - 17'(r_off));
    assign w_head_oob = (17'(r_off) + 17'(ffkvs_pkg::HEAD)) > 17'(STORE_SIZE);
    assign w_scnt_n   = (r_scnt < CW'(STG_DEPTH)) ? r_scnt + CW'(1) : r_scnt;
    assign w_bad_ins  = (w_klen == 8'd0) || (w_klen > 8'(KEY_MAX)) ||
                        (w_dlen > 7'(DATA_MAX)) ||
                        (10'(w_scnt_n) != 10'(w_klen) + 10'(w_dlen));
    assign w_bad_lkp  = (w_klen == 8'd0) || (w_klen > 8'(KEY_MAX)) ||
                        (10'(w_scnt_n) != 10'(w_klen));
    assign w_split    = (w_sz - r_rec) > 16'(ffkvs_pkg::BLK_MIN);

    always_comb begin
        w_room = r_bsz - 16'(ffkvs_pkg::BLK_MIN) - 16'(r_klen);
        w_dl16 = {8'd0, r_hdr[4]};
        if (w_dl16 > w_room) begin
            w_dl16 = w_room;
        end
        if (w_dl16 > 16'(DATA_MAX)) begin
            w_dl16 = 16'(DATA_MAX);
        end
        w_dl = w_dl16[6:0];
    end

    assign w_clr_p = 16'(r_cnt);

    always_comb begin
        st_we    = 1'b0;
        st_waddr = AW'(r_cnt);
        st_wdata = 8'd0;
        st_re    = 1'b0;
        st_raddr = AW'(r_off + r_cnt);
        sg_we    = w_acc && (w_act == ffkvs_pkg::ACT_INSERT || w_act == ffkvs_pkg::ACT_LOOKUP)
                   && (r_scnt < CW'(STG_DEPTH));
        sg_re    = 1'b0;
        sg_raddr = SW'(r_cnt);
        unique case (r_state)
            ffkvs_pkg::S_CLEAR: begin
                st_we = 1'b1;
                priority if (w_clr_p == 16'd0) begin
                    st_wdata = ffkvs_pkg::MARK_FREE;
                end else if (w_clr_p == 16'd1 || w_clr_p == STORE_SZ - 16'd2) begin
                    st_wdata = STORE_SZ[7:0];
                end else if (w_clr_p == 16'd2 || w_clr_p == STORE_SZ - 16'd1) begin
                    st_wdata = STORE_SZ[15:8];
                end else begin
                    st_wdata = 8'd0;
                end
            end
            ffkvs_pkg::S_HEAD: begin
                st_re = (r_cnt < OW'(ffkvs_pkg::HEAD));
            end
            ffkvs_pkg::S_KEY: begin
                st_re    = (r_cnt < OW'(r_klen));
                sg_re    = st_re;
                st_raddr = AW'(r_off + OW'(ffkvs_pkg::HEAD) + r_cnt);
            end
            ffkvs_pkg::S_DATA: begin
                st_re    = !r_ph;
                st_raddr = AW'(r_off + OW'(ffkvs_pkg::HEAD) + OW'(r_klen) + r_cnt);
            end
            ffkvs_pkg::S_FILL: begin
                sg_re    = (r_cnt < OW'(r_bsz));
                sg_raddr = SW'(r_cnt - OW'(ffkvs_pkg::HEAD));
                st_we    = r_wv;
                st_waddr = AW'(r_off + OW'(r_wp));
                priority if (r_wp == 16'd0) begin
                    st_wdata = ffkvs_pkg::MARK_USED;
                end else if (r_wp == 16'd1) begin
                    st_wdata = r_size[7:0];
                end else if (r_wp == 16'd2) begin
                    st_wdata = r_size[15:8];
                end else if (r_wp == 16'd3) begin
                    st_wdata = r_klen;
                end else if (r_wp == 16'd4) begin
                    st_wdata = {1'b0, r_dlen};
                end else if (r_wp < r_rec - 16'(ffkvs_pkg::TAIL)) begin
                    st_wdata = sg_rdata;
                end else if (r_wp == r_size - 16'd2) begin
                    st_wdata = r_size[7:0];
                end else if (r_wp == r_size - 16'd1) begin
                    st_wdata = r_size[15:8];
                end else if (r_split && r_wp == r_rec) begin
                    st_wdata = ffkvs_pkg::MARK_FREE;
                end else if (r_split && (r_wp == r_rec + 16'd1 || r_wp == r_bsz - 16'd2)) begin
                    st_wdata = r_rem[7:0];
                end else if (r_split && (r_wp == r_rec + 16'd2 || r_wp == r_bsz - 16'd1)) begin
                    st_wdata = r_rem[15:8];
                end else begin
                    st_wdata = 8'd0;
                end
            end
            default: begin
                st_re = 1'b0;
            end
        endcase
    end

    ffkvs_ram #(
        .WIDTH (8),
        .DEPTH (STORE_SIZE)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    ffkvs_ram #(
        .WIDTH (8),
        .DEPTH (STG_DEPTH)
    ) u_stage (
        .i_clk   (i_clk),
        .i_we    (sg_we),
        .i_waddr (r_scnt[SW-1:0]),
        .i_wdata (w_byte),
        .i_re    (sg_re),
        .i_raddr (sg_raddr),
        .o_rdata (sg_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (w_mload) begin
            r_mvalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_mvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ffkvs_pkg::S_CLEAR;
            r_cnt    <= '0;
            r_fmt    <= 1'b0;
            r_scnt   <= '0;
            r_wv     <= 1'b0;
            r_ph     <= 1'b0;
        end else begin
            unique case (r_state)
                ffkvs_pkg::S_CLEAR: begin
                    r_cnt <= r_cnt + OW'(1);
                    if (r_cnt == OW'(STORE_SIZE - 1)) begin
                        r_status <= ffkvs_pkg::ST_OK;
                        r_state  <= r_fmt ? ffkvs_pkg::S_RESP : ffkvs_pkg::S_IDLE;
                    end
                end
                ffkvs_pkg::S_IDLE: begin
                    if (w_acc) begin
                        unique case (w_act)
                            ffkvs_pkg::ACT_FORMAT: begin
                                r_state <= ffkvs_pkg::S_CLEAR;
                                r_cnt   <= '0;
                                r_fmt   <= 1'b1;
                                r_scnt  <= '0;
                            end
                            ffkvs_pkg::ACT_INSERT, ffkvs_pkg::ACT_LOOKUP: begin
                                if (!s_axis_tlast) begin
                                    r_scnt <= w_scnt_n;
                                end else begin
                                    r_scnt <= '0;
                                    r_klen <= w_klen;
                                    r_dlen <= w_dlen;
                                    r_op   <= (w_act == ffkvs_pkg::ACT_INSERT);
                                    r_rec  <= 16'(ffkvs_pkg::BLK_MIN) + 16'(w_klen)
                                              + 16'(w_dlen);
                                    r_off  <= '0;
                                    r_cnt  <= '0;
                                    if ((w_act == ffkvs_pkg::ACT_INSERT) ? w_bad_ins
                                                                         : w_bad_lkp) begin
                                        r_status <= ffkvs_pkg::ST_BAD_LEN;
                                        r_state  <= ffkvs_pkg::S_RESP;
                                    end else begin
                                        r_state <= ffkvs_pkg::S_HEAD;
                                    end
                                end
                            end
                            default: begin
                                r_state <= ffkvs_pkg::S_IDLE;
                            end
                        endcase
                    end
                end
                ffkvs_pkg::S_HEAD: begin
                    if (r_cnt == '0 && w_head_oob) begin
                        r_status <= r_op ? ffkvs_pkg::ST_NO_SPACE : ffkvs_pkg::ST_NOT_FOUND;
                        r_state  <= ffkvs_pkg::S_RESP;
                    end else begin
                        r_cnt <= r_cnt + OW'(1);
                        if (r_cnt != '0) begin
                            r_hdr[r_cnt[2:0] - 3'd1] <= st_rdata;
                        end
                        if (r_cnt == OW'(ffkvs_pkg::HEAD)) begin
                            r_state <= ffkvs_pkg::S_CHECK;
                        end
                    end
                end
                ffkvs_pkg::S_CHECK: begin
                    r_bsz <= w_sz;
                    r_cnt <= '0;
                    if (w_broken) begin
                        r_status <= r_op ? ffkvs_pkg::ST_NO_SPACE : ffkvs_pkg::ST_NOT_FOUND;
                        r_state  <= ffkvs_pkg::S_RESP;
                    end else if (r_op && r_hdr[0] == ffkvs_pkg::MARK_FREE && w_sz >= r_rec) begin
                        r_split <= w_split;
                        r_size  <= w_split ? r_rec : w_sz;
                        r_rem   <= w_sz - r_rec;
                        r_wv    <= 1'b0;
                        r_state <= ffkvs_pkg::S_FILL;
                    end else if (!r_op && r_hdr[0] == ffkvs_pkg::MARK_USED &&
                                 r_hdr[3] == r_klen &&
                                 16'(ffkvs_pkg::BLK_MIN) + 16'(r_klen) <= w_sz) begin
                        r_state <= ffkvs_pkg::S_KEY;
                    end else begin
                        r_off   <= r_off + OW'(w_sz);
                        r_state <= ffkvs_pkg::S_HEAD;
                    end
                end
                ffkvs_pkg::S_KEY: begin
                    if (r_cnt != '0 && st_rdata != sg_rdata) begin
                        r_off   <= r_off + OW'(r_bsz);
                        r_cnt   <= '0;
                        r_state <= ffkvs_pkg::S_HEAD;
                    end else if (r_cnt == OW'(r_klen)) begin
                        r_dl  <= w_dl;
                        r_cnt <= '0;
                        r_ph  <= 1'b0;
                        if (w_dl == 7'd0) begin
                            r_status <= ffkvs_pkg::ST_OK;
                            r_state  <= ffkvs_pkg::S_RESP;
                        end else begin
                            r_state <= ffkvs_pkg::S_DATA;
                        end
                    end else begin
                        r_cnt <= r_cnt + OW'(1);
                    end
                end
                ffkvs_pkg::S_DATA: begin
                    if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else if (w_slot) begin
                        r_mstat  <= ffkvs_pkg::ST_OK;
                        r_mdata  <= st_rdata;
                        r_mlen   <= r_dl;
                        r_mlast  <= (r_cnt + OW'(1) == OW'(r_dl));
                        r_cnt    <= r_cnt + OW'(1);
                        r_ph     <= 1'b0;
                        if (r_cnt + OW'(1) == OW'(r_dl)) begin
                            r_state <= ffkvs_pkg::S_IDLE;
                        end
                    end
                end
                ffkvs_pkg::S_FILL: begin
                    if (r_wv && r_wp == r_bsz - 16'd1) begin
                        r_wv     <= 1'b0;
                        r_status <= ffkvs_pkg::ST_OK;
                        r_state  <= ffkvs_pkg::S_RESP;
                    end else if (r_cnt < OW'(r_bsz)) begin
                        r_cnt <= r_cnt + OW'(1);
                        r_wv  <= 1'b1;
                        r_wp  <= 16'(r_cnt);
                    end else begin
                        r_wv <= 1'b0;
                    end
                end
                ffkvs_pkg::S_RESP: begin
                    if (w_slot) begin
                        r_mstat  <= r_status;
                        r_mdata  <= 8'd0;
                        r_mlen   <= 7'd0;
                        r_mlast  <= 1'b1;
                        r_fmt    <= 1'b0;
                        r_state  <= ffkvs_pkg::S_IDLE;
                    end
                end
                default: begin
                    r_state <= ffkvs_pkg::S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = {1'b0, r_mlen, r_mdata};
    assign m_axis_tlast  = r_mlast;
    assign m_axis_tuser  = r_mstat;

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_we |-> (r_state == ffkvs_pkg::S_FILL || r_state == ffkvs_pkg::S_CLEAR))
        else $error("store written outside fill or clear");

    a_fill_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ffkvs_pkg::S_FILL && r_wv) |-> (r_wp < r_bsz))
        else $error("fill write beyond chosen block");

    a_fill_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ffkvs_pkg::S_FILL) |-> (r_bsz >= r_rec))
        else $error("record placed in a block too small");

    a_data_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ffkvs_pkg::S_DATA) |-> (r_cnt < OW'(r_dl) && r_dl != 7'd0))
        else $error("data index past found length");

endmodule

### tb/sv/first_fit_key_value_store_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_key_value_store_tb
// Streams format, insert and lookup operations into the key/value store and
// checks every output transfer against a local byte-level store predictor.
// ----------------------------------------------------------------------------
module first_fit_key_value_store_tb;

    localparam int STORE_SIZE  = 4096;
    localparam int DATA_MAX    = 64;
    localparam int KEY_MAX     = 255;
    localparam int STAGE_DEPTH = KEY_MAX + DATA_MAX + 1;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int HEAD        = ffkvs_pkg::HEAD;
    localparam int TAIL        = ffkvs_pkg::TAIL;
    localparam int BLK_MIN     = ffkvs_pkg::BLK_MIN;

    typedef struct packed {
        ffkvs_pkg::t_action act;
        logic [7:0]         klen;
        logic [6:0]         dlen;
        logic [7:0]         bval;
        logic               last;
    } t_in_item;

    typedef struct packed {
        ffkvs_pkg::t_status status;
        logic [7:0]         data_byte;
        logic [6:0]         found_len;
        logic               final_res;
    } t_out_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;  // key_len, data_len, byte_value
    logic        s_axis_tlast = 1'b0;
    logic [1:0]  s_axis_tuser = '0;  // action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;       // data_byte, found_len
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;       // status

    first_fit_key_value_store dut (.*);

    always #4 i_clk = ~i_clk;

    t_in_item  pending_items[$];
    t_out_item expected_results[$];
    logic [7:0] model_store[STORE_SIZE];
    logic [7:0] model_stage[STAGE_DEPTH];
    int model_staged;
    int mismatch_count = 0;
    int cycle_count = 0;
    bit quiet_phase = 1'b0;
    int src_gap = 0;
    int sink_gap = 0;

    function automatic int rd16(int off);
        return int'(model_store[off]) | (int'(model_store[off + 1]) << 8);
    endfunction

    function automatic void wr16(int off, int v);
        model_store[off]     = v[7:0];
        model_store[off + 1] = v[15:8];
    endfunction

    function automatic void make_free(int off, int size);
        for (int i = 0; i < size; i++) model_store[off + i] = 8'h00;
        model_store[off] = ffkvs_pkg::MARK_FREE;
        wr16(off + 1, size);
        wr16(off + size - 2, size);
    endfunction

    function automatic int block_size(int off);
        int sz;
        if (off + HEAD > STORE_SIZE) return 0;
        sz = rd16(off + 1);
        if (sz < BLK_MIN || sz > STORE_SIZE - off) return 0;
        return sz;
    endfunction

    function automatic void push_result(ffkvs_pkg::t_status st, int db, int fl, bit fin);
        t_out_item r;
        r.status    = st;
        r.data_byte = db[7:0];
        r.found_len = fl[6:0];
        r.final_res = fin;
        expected_results.push_back(r);
    endfunction

    function automatic ffkvs_pkg::t_status place_record(int klen, int dlen, int count);
        int off, bsz, rec, size;
        if (klen == 0 || klen > KEY_MAX || dlen > DATA_MAX || count != klen + dlen)
            return ffkvs_pkg::ST_BAD_LEN;
        rec = HEAD + klen + dlen + TAIL;
        off = 0;
        forever begin
            bsz = block_size(off);
            if (bsz == 0) return ffkvs_pkg::ST_NO_SPACE;
            if (model_store[off] == ffkvs_pkg::MARK_FREE && bsz >= rec) break;
            off += bsz;
        end
        if (bsz - rec > BLK_MIN) begin
            size = rec;
            make_free(off + rec, bsz - rec);
        end else begin
            size = bsz;
        end
        for (int i = 0; i < size; i++) model_store[off + i] = 8'h00;
        model_store[off] = ffkvs_pkg::MARK_USED;
        wr16(off + 1, size);
        model_store[off + 3] = klen[7:0];
        model_store[off + 4] = dlen[7:0];
        for (int i = 0; i < klen + dlen; i++) model_store[off + HEAD + i] = model_stage[i];
        wr16(off + size - 2, size);
        return ffkvs_pkg::ST_OK;
    endfunction

    function automatic void find_record(int klen, int count);
        int off, bsz, dl, room;
        bit same;
        if (klen == 0 || klen > KEY_MAX || count != klen) begin
            push_result(ffkvs_pkg::ST_BAD_LEN, 0, 0, 1'b1);
            return;
        end
        off = 0;
        forever begin
            bsz = block_size(off);
            if (bsz == 0) break;
            if (model_store[off] == ffkvs_pkg::MARK_USED && model_store[off + 3] == klen
                    && HEAD + klen + TAIL <= bsz) begin
                same = 1'b1;
                for (int i = 0; i < klen; i++)
                    if (model_store[off + HEAD + i] != model_stage[i]) same = 1'b0;
                if (same) begin
                    dl = model_store[off + 4];
                    room = bsz - HEAD - klen - TAIL;
                    if (dl > room) dl = room;
                    if (dl > DATA_MAX) dl = DATA_MAX;
                    if (dl == 0) push_result(ffkvs_pkg::ST_OK, 0, 0, 1'b1);
                    for (int i = 0; i < dl; i++)
                        push_result(ffkvs_pkg::ST_OK, model_store[off + HEAD + klen + i], dl,
                                    i + 1 == dl);
                    return;
                end
            end
            off += bsz;
        end
        push_result(ffkvs_pkg::ST_NOT_FOUND, 0, 0, 1'b1);
    endfunction

    function automatic void format_model();
        for (int i = 0; i < STORE_SIZE; i++) model_store[i] = 8'h00;
        make_free(0, STORE_SIZE);
    endfunction

    function automatic void predict_item(t_in_item it);
        int count;
        if (it.act == ffkvs_pkg::ACT_FORMAT) begin
            format_model();
            model_staged = 0;
            push_result(ffkvs_pkg::ST_OK, 0, 0, 1'b1);
            return;
        end
        if (it.act == ffkvs_pkg::ACT_NONE) return;
        if (model_staged < STAGE_DEPTH) begin
            model_stage[model_staged] = it.bval;
            model_staged++;
        end
        if (!it.last) return;
        count = model_staged;
        model_staged = 0;
        if (it.act == ffkvs_pkg::ACT_INSERT)
            push_result(place_record(it.klen, it.dlen, count), 0, 0, 1'b1);
        else
            find_record(it.klen, count);
    endfunction

    // queue one operation; nbytes streamed, key/data lengths given on every byte
    task automatic queue_op(ffkvs_pkg::t_action act, int klen, int dlen, int nbytes,
                            int kseed);
        t_in_item it;
        for (int i = 0; i < nbytes; i++) begin
            it.act  = act;
            it.klen = klen[7:0];
            it.dlen = dlen[6:0];
            it.bval = (i < klen) ? 8'((kseed * 31 + i * 7) ^ (kseed >> 3))
                                 : 8'($urandom);
            it.last = (i == nbytes - 1);
            pending_items.push_back(it);
        end
    endtask

    task automatic queue_raw(ffkvs_pkg::t_action act, int klen, int dlen, int bval,
                             bit last);
        t_in_item it;
        it.act = act; it.klen = klen[7:0]; it.dlen = dlen[6:0];
        it.bval = bval[7:0]; it.last = last;
        pending_items.push_back(it);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d",
                 what, got, want, cycle_count);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !s_axis_tready) begin
            // hold
        end else begin
            if (s_axis_tvalid) predict_item(t_in_item'({s_axis_tuser, s_axis_tdata[7:0],
                s_axis_tdata[14:8], s_axis_tdata[22:15], s_axis_tlast}));
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
                src_gap <= $urandom_range(0, 14);
                s_axis_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                t_in_item it;
                it = pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= it.act;
                s_axis_tdata  <= {1'b0, it.bval, it.dlen, it.klen};
                s_axis_tlast  <= it.last;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected transfer status", m_axis_tuser, -1);
                end else begin
                    t_out_item e;
                    e = expected_results.pop_front();
                    if (m_axis_tuser != e.status)
                        report_mismatch("status", m_axis_tuser, e.status);
                    if (m_axis_tdata[7:0] != e.data_byte)
                        report_mismatch("data_byte", m_axis_tdata[7:0], e.data_byte);
                    if (m_axis_tdata[14:8] != e.found_len)
                        report_mismatch("found_len", m_axis_tdata[14:8], e.found_len);
                    if (m_axis_tlast != e.final_res)
                        report_mismatch("final_res", m_axis_tlast, e.final_res);
                end
            end
            if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_axis_tready <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
                sink_gap <= $urandom_range(0, 14);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int kl, dl, kk, n;
        int keys[$];
        format_model();
        model_staged = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: basic insert/lookup, extremes, errors
        queue_op(ffkvs_pkg::ACT_INSERT, 1, 0, 1, 1);
        queue_op(ffkvs_pkg::ACT_LOOKUP, 1, 0, 1, 1);
        queue_op(ffkvs_pkg::ACT_INSERT, 3, 64, 67, 2);
        queue_op(ffkvs_pkg::ACT_LOOKUP, 3, 0, 3, 2);
        queue_op(ffkvs_pkg::ACT_LOOKUP, 3, 0, 3, 9);                 // missing key
        queue_raw(ffkvs_pkg::ACT_INSERT, 0, 0, 8'hff, 1'b1);          // zero key length
        queue_raw(ffkvs_pkg::ACT_INSERT, 1, 127, 8'h00, 1'b1);        // data length too big
        queue_raw(ffkvs_pkg::ACT_LOOKUP, 2, 0, 8'h55, 1'b1);          // count mismatch
        queue_raw(ffkvs_pkg::ACT_NONE, 255, 127, 8'hff, 1'b1);        // ignored action
        queue_raw(ffkvs_pkg::ACT_INSERT, 1, 0, 8'h01, 1'b0);          // mixed actions
        queue_raw(ffkvs_pkg::ACT_LOOKUP, 2, 0, 8'h02, 1'b1);
        queue_op(ffkvs_pkg::ACT_INSERT, 1, 0, 1, 1);                  // duplicate key
        queue_op(ffkvs_pkg::ACT_LOOKUP, 1, 0, 1, 1);
        queue_op(ffkvs_pkg::ACT_FORMAT, 1, 0, 1, 0);
        while (pending_items.size() > 0 || expected_results.size() > 0)
            @(posedge i_clk);

        // random: inserts, lookups of stored and missing keys, stray items
        n = 0;
        while (n < 320) begin
            kk = $urandom_range(0, 99);
            if (kk < 3) begin
                queue_op(ffkvs_pkg::ACT_FORMAT, 1, 0, 1, 0);
                keys.delete();
                n++;
            end else if (kk < 50) begin
                kl = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 255)
                                                  : $urandom_range(1, 4);
                dl = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 64)
                                                 : $urandom_range(0, 8);
                keys.push_back(kl * 1000 + kk);
                queue_op(ffkvs_pkg::ACT_INSERT, kl, dl, kl + dl, kk);
                n += kl + dl;
            end else if (kk < 90 && keys.size() > 0) begin
                int pick;
                pick = keys[$urandom_range(0, keys.size() - 1)];
                kl = pick / 1000;
                queue_op(ffkvs_pkg::ACT_LOOKUP, kl, $urandom_range(0, 127), kl, pick % 1000);
                n += kl;
            end else if (kk < 95) begin
                kl = $urandom_range(1, 4);
                queue_op(ffkvs_pkg::ACT_LOOKUP, kl, 0, kl, $urandom_range(0, 255));
                n += kl;
            end else begin
                queue_raw(ffkvs_pkg::t_action'($urandom_range(1, 3)), $urandom_range(0, 255),
                          $urandom_range(0, 127), $urandom_range(0, 255), 1'b1);
                n++;
            end
            if (n > 260) quiet_phase = 1'b1;
            while (pending_items.size() > 200) @(posedge i_clk);
        end
        quiet_phase = 1'b1;
        while (pending_items.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (2000) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### first_fit_key_value_store.f
design/ffkvs_pkg.sv
design/ffkvs_ram.sv
design/first_fit_key_value_store.sv
tb/sv/first_fit_key_value_store_tb.sv
